// ===== src/ssqs_pkg.sv =====
`default_nettype none

package ssqs_pkg;

    // Queue depth used unless the top level is given another.
    localparam int QUEUE_DEPTH_DEFAULT = 128;

    // Input opcodes.
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SERVICE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH        = 2'd2;

    // Register reset values.
    localparam logic [16:0] THRESHOLD_RESET   = 17'd32768;
    localparam logic [7:0]  MAX_SERVICE_RESET = 8'd5;
    localparam logic [31:0] RUN_LENGTH_RESET  = 32'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [16:0] arrival_threshold;
        logic [7:0]  max_service;
        logic [31:0] run_length;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic evaluate;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== src/single_server_queue_simulator.sv =====
`default_nettype none

// Single-server FIFO queue simulator, advanced one tick per input beat.
// Input channel (in_valid / in_stall): each beat carries an opcode and two
// random 0.16 fractions. Opcode zero starts a new run and clears the queue,
// clock and totals; opcode one advances the simulation by one tick.
// Output channel (out_valid / out_stall): exactly one result beat per input
// beat, in order, carrying the tick, arrival and service events and totals.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): writes
// the arrival threshold, the largest service time and the run length. It is
// always ready and should only be used while no beat is in flight.
// Sequence: an accepted input beat is captured, then the controller steps
// through a read cycle, in which the queue memory head entry and the
// service product are registered, and a commit cycle that writes the
// result register. A new input beat is taken only after the commit.
// If the receiver stalls, the commit waits until the result register is
// free and no further input is taken meanwhile; nothing is lost.
// Reset clears the run state and loads the register reset values; queue
// memory contents are never cleared, as only written entries are read.

module single_server_queue_simulator #(
    parameter int QUEUE_DEPTH = ssqs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input channel.
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           opcode,
    input  wire logic [15:0]                    arrival_draw,
    input  wire logic [15:0]                    service_draw,
    // Output channel.
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [31:0]                         clock_now,
    output logic                                arrived,
    output logic [15:0]                         arrival_id,
    output logic                                dropped,
    output logic                                started,
    output logic [15:0]                         started_id,
    output logic [15:0]                         wait_time,
    output logic [15:0]                         served_count,
    output logic [31:0]                         total_wait,
    output logic [7:0]                          waiting_count,
    output logic [7:0]                          service_left,
    output logic                                run_over,
    // Configuration channel.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ssqs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    ssqs_pkg::cfg_t    cfg_reg;
    ssqs_pkg::cmd_t    cmd;
    ssqs_pkg::status_t status;

    // The configuration registers accept a write in every cycle.
    assign cfg_ready = 1'b1;

    // Writes to an index beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arrival_threshold <= ssqs_pkg::THRESHOLD_RESET;
            cfg_reg.max_service       <= ssqs_pkg::MAX_SERVICE_RESET;
            cfg_reg.run_length        <= ssqs_pkg::RUN_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ssqs_pkg::CFG_ARRIVAL_THRESHOLD:
                begin
                    cfg_reg.arrival_threshold <= cfg_data[16:0];
                end
                ssqs_pkg::CFG_MAX_SERVICE:
                begin
                    cfg_reg.max_service <= cfg_data[7:0];
                end
                ssqs_pkg::CFG_RUN_LENGTH:
                begin
                    cfg_reg.run_length <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: capture, read and commit steps for each beat.
    ssqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Queue memory, simulation state and the result register.
    ssqs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg_reg),
        .opcode        (opcode),
        .arrival_draw  (arrival_draw),
        .service_draw  (service_draw),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .clock_now     (clock_now),
        .arrived       (arrived),
        .arrival_id    (arrival_id),
        .dropped       (dropped),
        .started       (started),
        .started_id    (started_id),
        .wait_time     (wait_time),
        .served_count  (served_count),
        .total_wait    (total_wait),
        .waiting_count (waiting_count),
        .service_left  (service_left),
        .run_over      (run_over)
    );

endmodule

`default_nettype wire

// ===== src/ssqs_ctrl.sv =====
`default_nettype none

module ssqs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ssqs_pkg::status_t status,
    output ssqs_pkg::cmd_t         cmd
);

    ssqs_pkg::state_t state_reg;
    ssqs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssqs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_stall     = 1'b1;
        cmd.capture  = 1'b0;
        cmd.evaluate = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            ssqs_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ssqs_pkg::ST_READ;
                end
            end
            ssqs_pkg::ST_READ:
            begin
                cmd.evaluate = 1'b1;
                state_next   = ssqs_pkg::ST_COMMIT;
            end
            ssqs_pkg::ST_COMMIT:
            begin
                // The result register must be free before the state moves on.
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ssqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssqs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/ssqs_datapath.sv =====
`default_nettype none

module ssqs_datapath #(
    parameter int QUEUE_DEPTH = ssqs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ssqs_pkg::cmd_t    cmd,
    output ssqs_pkg::status_t      status,
    input  wire ssqs_pkg::cfg_t    cfg,
    input  wire logic              opcode,
    input  wire logic [15:0]       arrival_draw,
    input  wire logic [15:0]       service_draw,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [31:0]            clock_now,
    output logic                   arrived,
    output logic [15:0]            arrival_id,
    output logic                   dropped,
    output logic                   started,
    output logic [15:0]            started_id,
    output logic [15:0]            wait_time,
    output logic [15:0]            served_count,
    output logic [31:0]            total_wait,
    output logic [7:0]             waiting_count,
    output logic [7:0]             service_left,
    output logic                   run_over
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    // Queue entry: customer number, tick before arrival, service time.
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] tick;
        logic [7:0]  svc;
    } entry_t;

    entry_t mem [QUEUE_DEPTH];
    entry_t rdata_reg;

    // Simulation state.
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [31:0]      tick_reg;
    logic [7:0]       rem_reg;
    logic [15:0]      arrived_cnt_reg;
    logic [15:0]      served_reg;
    logic [31:0]      total_reg;

    // Captured item.
    logic        op_reg;
    logic [15:0] adraw_reg;
    logic [15:0] sdraw_reg;

    // Decisions and operands prepared in the read cycle.
    logic        over_reg;
    logic        hit_reg;
    logic        full_reg;
    logic        busy_reg;
    logic        empty_reg;
    logic [7:0]  svc_reg;
    logic [15:0] head_id_reg;
    logic [7:0]  head_svc_reg;
    logic [31:0] head_wait_reg;

    // Result register.
    logic        out_valid_reg;
    logic [31:0] clock_now_reg;
    logic        arrived_reg;
    logic [15:0] arrival_id_reg;
    logic        dropped_reg;
    logic        started_reg;
    logic [15:0] started_id_reg;
    logic [15:0] wait_time_reg;
    logic [15:0] served_count_reg;
    logic [31:0] total_wait_reg;
    logic [7:0]  waiting_count_reg;
    logic [7:0]  service_left_reg;
    logic        run_over_reg;

    // Commit-cycle logic.
    logic             do_arr;
    logic             do_drop;
    logic             do_start;
    logic             forward;
    logic [15:0]      new_id;
    logic [15:0]      st_id;
    logic [7:0]       st_svc;
    logic [31:0]      st_wait;
    logic [32:0]      total_sum;
    logic [31:0]      total_next;
    logic [15:0]      served_next;
    logic [OCC_W-1:0] occ_next;
    logic [OCC_W+7:0] occ_wide;
    logic [7:0]       rem_next;
    logic [23:0]      svc_prod;
    entry_t           wdata;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign status.out_free = !out_valid_reg || !out_stall;

    assign svc_prod = cfg.max_service * sdraw_reg;

    always_comb
    begin
        do_arr   = hit_reg && !full_reg;
        do_drop  = hit_reg && full_reg;
        do_start = !busy_reg && (!empty_reg || do_arr);
        // An empty queue means the starting customer is the one arriving now.
        forward  = empty_reg;
        new_id   = arrived_cnt_reg + 16'd1;
        st_id    = forward ? new_id : head_id_reg;
        st_svc   = forward ? svc_reg : head_svc_reg;
        st_wait  = forward ? 32'd0 : head_wait_reg;
        total_sum  = {1'b0, total_reg} + {1'b0, st_wait};
        total_next = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
        served_next = (served_reg == 16'hFFFF) ? served_reg : served_reg + 16'd1;
        occ_next = occ_reg;
        if (do_arr && !do_start)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (!do_arr && do_start)
        begin
            occ_next = occ_reg - 1'b1;
        end
        occ_wide = {8'd0, occ_next};
        if (busy_reg)
        begin
            rem_next = rem_reg - 8'd1;
        end
        else if (do_start)
        begin
            rem_next = st_svc - 8'd1;
        end
        else
        begin
            rem_next = rem_reg;
        end
        wdata.id   = new_id;
        wdata.tick = tick_reg;
        wdata.svc  = svc_reg;
    end

    // Queue storage: one write port, one registered read port at the head.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && op_reg == ssqs_pkg::OP_TICK && !over_reg && do_arr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
        rdata_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            adraw_reg <= arrival_draw;
            sdraw_reg <= service_draw;
        end
        if (cmd.evaluate)
        begin
            over_reg      <= tick_reg >= cfg.run_length;
            hit_reg       <= {1'b0, adraw_reg} < cfg.arrival_threshold;
            full_reg      <= occ_reg == OCC_W'(QUEUE_DEPTH);
            busy_reg      <= rem_reg != 8'd0;
            empty_reg     <= occ_reg == '0;
            svc_reg       <= svc_prod[23:16] + 8'd1;
            head_id_reg   <= rdata_reg.id;
            head_svc_reg  <= rdata_reg.svc;
            head_wait_reg <= tick_reg - rdata_reg.tick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            occ_reg         <= '0;
            tick_reg        <= '0;
            rem_reg         <= '0;
            arrived_cnt_reg <= '0;
            served_reg      <= '0;
            total_reg       <= '0;
        end
        else if (cmd.commit)
        begin
            if (op_reg == ssqs_pkg::OP_CLEAR)
            begin
                rd_ptr_reg      <= '0;
                wr_ptr_reg      <= '0;
                occ_reg         <= '0;
                tick_reg        <= '0;
                rem_reg         <= '0;
                arrived_cnt_reg <= '0;
                served_reg      <= '0;
                total_reg       <= '0;
            end
            else if (!over_reg)
            begin
                tick_reg <= tick_reg + 32'd1;
                occ_reg  <= occ_next;
                rem_reg  <= rem_next;
                if (do_arr)
                begin
                    arrived_cnt_reg <= new_id;
                    wr_ptr_reg      <= next_slot(wr_ptr_reg);
                end
                if (do_start)
                begin
                    rd_ptr_reg <= next_slot(rd_ptr_reg);
                    served_reg <= served_next;
                    total_reg  <= total_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (op_reg == ssqs_pkg::OP_CLEAR)
            begin
                clock_now_reg     <= '0;
                arrived_reg       <= 1'b0;
                arrival_id_reg    <= '0;
                dropped_reg       <= 1'b0;
                started_reg       <= 1'b0;
                started_id_reg    <= '0;
                wait_time_reg     <= '0;
                served_count_reg  <= '0;
                total_wait_reg    <= '0;
                waiting_count_reg <= '0;
                service_left_reg  <= '0;
                run_over_reg      <= 1'b0;
            end
            else if (over_reg)
            begin
                clock_now_reg     <= tick_reg;
                arrived_reg       <= 1'b0;
                arrival_id_reg    <= '0;
                dropped_reg       <= 1'b0;
                started_reg       <= 1'b0;
                started_id_reg    <= '0;
                wait_time_reg     <= '0;
                served_count_reg  <= served_reg;
                total_wait_reg    <= total_reg;
                waiting_count_reg <= 8'(occ_reg);
                service_left_reg  <= rem_reg;
                run_over_reg      <= 1'b1;
            end
            else
            begin
                clock_now_reg     <= tick_reg + 32'd1;
                arrived_reg       <= do_arr;
                arrival_id_reg    <= do_arr ? new_id : 16'd0;
                dropped_reg       <= do_drop;
                started_reg       <= do_start;
                started_id_reg    <= do_start ? st_id : 16'd0;
                wait_time_reg     <= !do_start ? 16'd0 :
                                     (|st_wait[31:16]) ? 16'hFFFF : st_wait[15:0];
                served_count_reg  <= do_start ? served_next : served_reg;
                total_wait_reg    <= do_start ? total_next : total_reg;
                waiting_count_reg <= occ_wide[7:0];
                service_left_reg  <= rem_next;
                run_over_reg      <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign clock_now     = clock_now_reg;
    assign arrived       = arrived_reg;
    assign arrival_id    = arrival_id_reg;
    assign dropped       = dropped_reg;
    assign started       = started_reg;
    assign started_id    = started_id_reg;
    assign wait_time     = wait_time_reg;
    assign served_count  = served_count_reg;
    assign total_wait    = total_wait_reg;
    assign waiting_count = waiting_count_reg;
    assign service_left  = service_left_reg;
    assign run_over      = run_over_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("result committed over an untaken result");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && op_reg == ssqs_pkg::OP_CLEAR |=> occ_reg == '0 && tick_reg == 32'd0)
        else $error("new run left state behind");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && op_reg == ssqs_pkg::OP_TICK && !over_reg && do_start
        |-> !busy_reg && (occ_reg != '0 || do_arr))
        else $error("service started while busy or with no customer");

    a_arr_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(arrived_reg && dropped_reg))
        else $error("arrival both queued and dropped");

endmodule

`default_nettype wire
